// File: design/vaa_pkg.sv
`default_nettype none

package vaa_pkg;

  localparam int COORD_W = 24;
  localparam int COORDS = 6;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W = 51;
  localparam int MAG_W = 50;
  localparam int NORM_W = 60;
  localparam int CORDIC_W = 63;
  localparam int Z_W = 33;
  localparam int ANGLE_W = 31;
  localparam int LIMIT_W = 20;
  localparam int CORDIC_STEPS = 32;

  localparam int GROUP_W = 8;
  localparam int GROUPS = 7;
  localparam int COARSE_W = 3;
  localparam int FINE_W = 4;

  localparam int IN_DATA_W = COORDS * COORD_W;
  localparam int OUT_DATA_W = ((ANGLE_W + DOT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - ANGLE_W - DOT_W;

  localparam logic [ANGLE_W-1:0] ANGLE_PI = 31'd1686629713;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF_PI = 31'd843314857;

  localparam int ATAN_HEAD_N = 10;
  localparam int ATAN_LAST = 29;
  localparam logic [Z_W-1:0] ATAN_HEAD [ATAN_HEAD_N] = '{
    33'd421657428, 33'd248918915, 33'd131521918, 33'd66762579, 33'd33510843,
    33'd16771758, 33'd8387925, 33'd4194219, 33'd2097141, 33'd1048575
  };

  typedef struct packed {
    logic [DOT_W-1:0] dot;
    logic             near_zero;
    logic             quarter;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
  } mag_vec_t;

  typedef struct packed {
    logic [NORM_W-1:0] x;
    logic [NORM_W-1:0] y;
  } norm_vec_t;

  function automatic logic [Z_W-1:0] atan_step(input int i);
    logic [Z_W-1:0] r;
    if (i < ATAN_HEAD_N) begin
      r = ATAN_HEAD[i];
    end else if (i <= ATAN_LAST) begin
      r = Z_W'(1) << (ATAN_LAST - i);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/vector_angle_atan2_folded.sv
// channel   dir  handshake              payload
// cfg       in   cfg_wr_en              cfg_wr_data: near_zero_limit
// s_axis    in   tvalid/tready          tdata: left_x .. right_y, 24 bits each
// m_axis    out  tvalid/tready          tdata: angle_rad, dot_value; tuser: near_zero
//
// one word per cycle while the output is not stalled
// the pipeline holds the 32 cordic iterations, one per pipeline stage,
// plus 4 front stages, 2 normalize stages and the output register
// each stage holds its word under back pressure and fills bubbles
// synchronous reset clears valid bits and the limit register
`default_nettype none

module vector_angle_atan2_folded (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [vaa_pkg::LIMIT_W-1:0]     cfg_wr_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // left_x, left_y, vertex_x, vertex_y, right_x, right_y
  input  wire logic [vaa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // angle_rad, dot_value, zero pad
  output logic [vaa_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // near_zero
  output logic                                 m_axis_tuser
);

  logic [vaa_pkg::LIMIT_W-1:0] near_zero_limit;

  logic               f_valid, f_ready;
  vaa_pkg::mag_vec_t  f_vec;
  vaa_pkg::side_t     f_side;

  logic               n_valid, n_ready;
  vaa_pkg::norm_vec_t n_vec;
  vaa_pkg::side_t     n_side;

  logic                           c_valid, c_ready;
  logic signed [vaa_pkg::Z_W-1:0] c_z;
  vaa_pkg::side_t                 c_side;

  logic signed [vaa_pkg::Z_W-1:0] off, z_sum;
  logic [vaa_pkg::ANGLE_W-1:0]    angle_next;

  logic                           o_valid;
  logic [vaa_pkg::ANGLE_W-1:0]    angle_rad;
  logic [vaa_pkg::DOT_W-1:0]      dot_value;
  logic                           near_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= '0;
    end else if (cfg_wr_en) begin
      near_zero_limit <= cfg_wr_data;
    end
  end

  vaa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .limit     (near_zero_limit),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_vec   (f_vec),
    .out_side  (f_side)
  );

  vaa_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_vec    (f_vec),
    .in_side   (f_side),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .out_vec   (n_vec),
    .out_side  (n_side)
  );

  vaa_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .in_vec    (n_vec),
    .in_side   (n_side),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_z     (c_z),
    .out_side  (c_side)
  );

  // add back the quarter turn, clamp to [0, pi], zero when near_zero is set
  always_comb begin
    off = c_side.quarter ? $signed(vaa_pkg::Z_W'(vaa_pkg::ANGLE_HALF_PI)) : '0;
    z_sum = c_z + off;
    if (c_side.near_zero || z_sum[vaa_pkg::Z_W-1]) begin
      angle_next = '0;
    end else if (z_sum > $signed(vaa_pkg::Z_W'(vaa_pkg::ANGLE_PI))) begin
      angle_next = vaa_pkg::ANGLE_PI;
    end else begin
      angle_next = vaa_pkg::ANGLE_W'(z_sum);
    end
  end

  assign c_ready = !o_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (c_ready) begin
      o_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && c_valid) begin
      angle_rad <= angle_next;
      dot_value <= c_side.dot;
      near_zero <= c_side.near_zero;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {{vaa_pkg::OUT_PAD_W{1'b0}}, dot_value, angle_rad};
  assign m_axis_tuser  = near_zero;

endmodule

`default_nettype wire

// File: design/vaa_front.sv
`default_nettype none

module vaa_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [vaa_pkg::LIMIT_W-1:0]      limit,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [vaa_pkg::IN_DATA_W-1:0]    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output vaa_pkg::mag_vec_t                     out_vec,
  output vaa_pkg::side_t                        out_side
);

  logic signed [vaa_pkg::COORD_W-1:0] lx, ly, vx, vy, rx, ry;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [vaa_pkg::DIFF_W-1:0] dx1, dy1, dx2, dy2;
  logic signed [vaa_pkg::PROD_W-1:0] p_xx, p_yy, p_xy, p_yx;
  logic signed [vaa_pkg::DOT_W-1:0]  dot, cross_prod;

  logic signed [vaa_pkg::DOT_W-1:0]  neg_dot, neg_cross, lim_s, nlim_s;
  logic signed [vaa_pkg::DOT_W-1:0]  fx, fy;
  logic                              fq, small_next;

  vaa_pkg::mag_vec_t vec;
  vaa_pkg::side_t    side;

  assign lx = in_data[0*vaa_pkg::COORD_W +: vaa_pkg::COORD_W];
  assign ly = in_data[1*vaa_pkg::COORD_W +: vaa_pkg::COORD_W];
  assign vx = in_data[2*vaa_pkg::COORD_W +: vaa_pkg::COORD_W];
  assign vy = in_data[3*vaa_pkg::COORD_W +: vaa_pkg::COORD_W];
  assign rx = in_data[4*vaa_pkg::COORD_W +: vaa_pkg::COORD_W];
  assign ry = in_data[5*vaa_pkg::COORD_W +: vaa_pkg::COORD_W];

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // edge vectors from the vertex
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dx1 <= vaa_pkg::DIFF_W'(lx) - vaa_pkg::DIFF_W'(vx);
      dy1 <= vaa_pkg::DIFF_W'(ly) - vaa_pkg::DIFF_W'(vy);
      dx2 <= vaa_pkg::DIFF_W'(rx) - vaa_pkg::DIFF_W'(vx);
      dy2 <= vaa_pkg::DIFF_W'(ry) - vaa_pkg::DIFF_W'(vy);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p_xx <= dx1 * dx2;
      p_yy <= dy1 * dy2;
      p_xy <= dx1 * dy2;
      p_yx <= dy1 * dx2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      dot        <= vaa_pkg::DOT_W'(p_xx) + vaa_pkg::DOT_W'(p_yy);
      cross_prod <= vaa_pkg::DOT_W'(p_xy) - vaa_pkg::DOT_W'(p_yx);
    end
  end

  // fold into the first quadrant, quarter turn flagged, near-zero test against the limit
  always_comb begin
    neg_dot   = -dot;
    neg_cross = -cross_prod;
    lim_s     = $signed(vaa_pkg::DOT_W'(limit));
    nlim_s    = -lim_s;
    if (!cross_prod[vaa_pkg::DOT_W-1]) begin
      if (!dot[vaa_pkg::DOT_W-1]) begin
        fx = dot;
        fy = cross_prod;
        fq = 1'b0;
      end else begin
        fx = cross_prod;
        fy = neg_dot;
        fq = 1'b1;
      end
    end else begin
      if (!dot[vaa_pkg::DOT_W-1] && (dot != '0)) begin
        fx = neg_cross;
        fy = dot;
        fq = 1'b1;
      end else begin
        fx = neg_dot;
        fy = neg_cross;
        fq = 1'b0;
      end
    end
    small_next = (dot <= lim_s) && (dot >= nlim_s) &&
                 (cross_prod <= lim_s) && (cross_prod >= nlim_s);
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      vec.x          <= vaa_pkg::MAG_W'(fx);
      vec.y          <= vaa_pkg::MAG_W'(fy);
      side.dot       <= dot;
      side.near_zero <= small_next;
      side.quarter   <= fq;
    end
  end

  assign out_valid = v4;
  assign out_vec   = vec;
  assign out_side  = side;

endmodule

`default_nettype wire

// File: design/vaa_norm.sv
`default_nettype none

module vaa_norm (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire vaa_pkg::mag_vec_t   in_vec,
  input  wire vaa_pkg::side_t      in_side,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output vaa_pkg::norm_vec_t       out_vec,
  output vaa_pkg::side_t           out_side
);

  logic va, vb;
  logic rdya, rdyb;

  logic [vaa_pkg::NORM_W-1:0]   wn, xn, yn;
  logic [vaa_pkg::COARSE_W-1:0] coarse;
  logic                         hit_c;

  logic [vaa_pkg::NORM_W-1:0]   xa, ya;
  vaa_pkg::side_t               side_a;

  logic [vaa_pkg::GROUP_W-1:0]  top;
  logic [vaa_pkg::FINE_W-1:0]   fine;
  logic                         hit_f;

  vaa_pkg::norm_vec_t           vec_b;
  vaa_pkg::side_t               side_b;

  assign rdyb = !vb || out_ready;
  assign rdya = !va || rdyb;
  assign in_ready = rdya;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdya) va <= in_valid;
      if (rdyb) vb <= va;
    end
  end

  // coarse leading-zero count, whole bytes
  always_comb begin
    xn = vaa_pkg::NORM_W'(in_vec.x);
    yn = vaa_pkg::NORM_W'(in_vec.y);
    wn = xn | yn;
    coarse = '0;
    hit_c = 1'b0;
    for (int g = 0; g < vaa_pkg::GROUPS; g++) begin
      if (!hit_c) begin
        if (|wn[vaa_pkg::NORM_W-1-g*vaa_pkg::GROUP_W -: vaa_pkg::GROUP_W]) begin
          hit_c = 1'b1;
        end else begin
          coarse = coarse + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdya && in_valid) begin
      xa     <= xn << {coarse, 3'b000};
      ya     <= yn << {coarse, 3'b000};
      side_a <= in_side;
    end
  end

  // fine count within the top byte
  always_comb begin
    top = xa[vaa_pkg::NORM_W-1 -: vaa_pkg::GROUP_W] | ya[vaa_pkg::NORM_W-1 -: vaa_pkg::GROUP_W];
    fine = '0;
    hit_f = 1'b0;
    for (int b = vaa_pkg::GROUP_W - 1; b >= 0; b--) begin
      if (!hit_f) begin
        if (top[b]) begin
          hit_f = 1'b1;
        end else begin
          fine = fine + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdyb && va) begin
      vec_b.x <= xa << fine;
      vec_b.y <= ya << fine;
      side_b  <= side_a;
    end
  end

  assign out_valid = vb;
  assign out_vec   = vec_b;
  assign out_side  = side_b;

endmodule

`default_nettype wire

// File: design/vaa_cordic.sv
`default_nettype none

module vaa_cordic (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire vaa_pkg::norm_vec_t          in_vec,
  input  wire vaa_pkg::side_t              in_side,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [vaa_pkg::Z_W-1:0]   out_z,
  output vaa_pkg::side_t                   out_side
);

  localparam int N = vaa_pkg::CORDIC_STEPS;

  logic signed [vaa_pkg::CORDIC_W-1:0] xs [N];
  logic signed [vaa_pkg::CORDIC_W-1:0] ys [N];
  logic signed [vaa_pkg::Z_W-1:0]      zs [N+1];
  vaa_pkg::side_t                      sd [N+1];
  logic                                vld [N+1];
  logic                                rdy [N+1];

  assign xs[0]  = vaa_pkg::CORDIC_W'(in_vec.x);
  assign ys[0]  = vaa_pkg::CORDIC_W'(in_vec.y);
  assign zs[0]  = '0;
  assign sd[0]  = in_side;
  assign vld[0] = in_valid;
  assign rdy[N] = out_ready;
  assign in_ready = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [vaa_pkg::Z_W-1:0] ATAN = $signed(vaa_pkg::atan_step(i));

    logic                           v_q;
    logic signed [vaa_pkg::Z_W-1:0] z_q;
    vaa_pkg::side_t                 sd_q;
    logic                           up;

    assign up = !ys[i][vaa_pkg::CORDIC_W-1];
    assign rdy[i] = !v_q || rdy[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (rdy[i]) begin
        v_q <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vld[i]) begin
        z_q  <= up ? zs[i] + ATAN : zs[i] - ATAN;
        sd_q <= sd[i];
      end
    end

    assign vld[i+1] = v_q;
    assign zs[i+1]  = z_q;
    assign sd[i+1]  = sd_q;

    if (i < N - 1) begin : g_xy
      logic signed [vaa_pkg::CORDIC_W-1:0] x_sh, y_sh, x_q, y_q;

      assign x_sh = xs[i] >>> i;
      assign y_sh = ys[i] >>> i;

      always_ff @(posedge clk) begin
        if (rdy[i] && vld[i]) begin
          if (up) begin
            x_q <= xs[i] + y_sh;
            y_q <= ys[i] - x_sh;
          end else begin
            x_q <= xs[i] - y_sh;
            y_q <= ys[i] + x_sh;
          end
        end
      end

      assign xs[i+1] = x_q;
      assign ys[i+1] = y_q;
    end
  end

  assign out_valid = vld[N];
  assign out_z     = zs[N];
  assign out_side  = sd[N];

endmodule

`default_nettype wire

// File: tb/vaa_result_checker.sv
module vaa_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [vaa_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // left_x, left_y, vertex_x, vertex_y, right_x, right_y
  input  logic [vaa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // angle_rad, dot_value, zero pad
  input  logic [vaa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // near_zero
  input  logic                           m_axis_tuser,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             flagged
);
  import vaa_pkg::*;

  typedef struct {
    logic [ANGLE_W-1:0] angle_rad;
    logic [DOT_W-1:0]   dot_value;
    logic               near_zero;
  } angle_word_t;

  localparam longint ARCTAN_TAB [10] = '{
    421657428, 248918915, 131521918, 66762579, 33510843,
    16771758, 8387925, 4194219, 2097141, 1048575
  };

  logic [LIMIT_W-1:0] near_limit = '0;
  angle_word_t        expected_angles [$];
  angle_word_t        want;
  angle_word_t        got;
  int                 mismatch_count = 0;
  int                 checked_count = 0;
  int                 flagged_count = 0;

  function automatic longint arctan_weight(input int i);
    if (i < 10) begin
      return ARCTAN_TAB[i];
    end else if (i <= 29) begin
      return longint'(1) << (29 - i);
    end
    return 0;
  endfunction

  function automatic angle_word_t predict_angle(input logic [IN_DATA_W-1:0] pts);
    longint      coord [COORDS];
    longint      dx1, dy1, dx2, dy2, dot_p, cross_p;
    longint      x, y, z, offset, t, xs, ys;
    longint unsigned ux, uy, big;
    int          i;
    angle_word_t r;
    for (i = 0; i < COORDS; i++) begin
      coord[i] = longint'($signed(pts[i*COORD_W +: COORD_W]));
    end
    dx1 = coord[0] - coord[2];
    dy1 = coord[1] - coord[3];
    dx2 = coord[4] - coord[2];
    dy2 = coord[5] - coord[3];
    dot_p = dx1 * dx2 + dy1 * dy2;
    cross_p = dx1 * dy2 - dy1 * dx2;
    r.dot_value = dot_p[DOT_W-1:0];
    r.near_zero = ((dot_p < 0 ? -dot_p : dot_p) <= longint'(near_limit)) &&
                  ((cross_p < 0 ? -cross_p : cross_p) <= longint'(near_limit));
    z = 0;
    if (!r.near_zero) begin
      // fold into the upper half plane, then rotate into the right half
      x = dot_p;
      y = cross_p;
      offset = 0;
      if (y < 0) begin
        x = -x;
        y = -y;
      end
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        offset = longint'(ANGLE_HALF_PI);
      end
      ux = x;
      uy = y;
      if (ux != 0 || uy != 0) begin
        big = (ux > uy) ? ux : uy;
        while (big < (64'd1 << 59)) begin
          big = big << 1;
          ux = ux << 1;
          uy = uy << 1;
        end
        while (big >= (64'd1 << 60)) begin
          big = big >> 1;
          ux = ux >> 1;
          uy = uy >> 1;
        end
        x = ux;
        y = uy;
        for (i = 0; i < CORDIC_STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_weight(i);
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_weight(i);
          end
        end
        z = z + offset;
        if (z < 0) begin
          z = 0;
        end
        if (z > longint'(ANGLE_PI)) begin
          z = longint'(ANGLE_PI);
        end
      end
    end
    r.angle_rad = z[ANGLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      near_limit = '0;
    end else begin
      if (cfg_wr_en) begin
        near_limit = cfg_wr_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_angles.push_back(predict_angle(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.angle_rad = m_axis_tdata[ANGLE_W-1:0];
        got.dot_value = m_axis_tdata[ANGLE_W +: DOT_W];
        got.near_zero = m_axis_tuser;
        if (expected_angles.size() == 0) begin
          $error("output word with no expected result, angle_rad %0d", got.angle_rad);
          mismatch_count++;
        end else begin
          want = expected_angles.pop_front();
          checked_count++;
          if (got.near_zero) begin
            flagged_count++;
          end
          if (got.angle_rad !== want.angle_rad) begin
            $error("angle_rad mismatch: expected %0d, actual %0d",
                   want.angle_rad, got.angle_rad);
            mismatch_count++;
          end
          if (got.dot_value !== want.dot_value) begin
            $error("dot_value mismatch: expected %0d, actual %0d",
                   $signed(want.dot_value), $signed(got.dot_value));
            mismatch_count++;
          end
          if (got.near_zero !== want.near_zero) begin
            $error("near_zero mismatch: expected %0d, actual %0d",
                   want.near_zero, got.near_zero);
            mismatch_count++;
          end
        end
      end
    end
    errors <= mismatch_count;
    pending <= expected_angles.size();
    checked <= checked_count;
    flagged <= flagged_count;
  end

endmodule

// File: tb/tb_vector_angle_atan2_folded.sv
module tb_vector_angle_atan2_folded;
  import vaa_pkg::*;

  localparam int PIPE_LAT = 45;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] C_MIN = 24'h800000;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 20'hFFFFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  int errors;
  int pending;
  int checked;
  int flagged;
  int words_sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  vector_angle_atan2_folded u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  vaa_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .flagged       (flagged)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = hold_req ? HOLD_CYCLES : (idle_on ? $urandom_range(0, 5) : 0);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hold_req = 1'b0;
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_pts(input logic [COORD_W-1:0] lx, ly, vx, vy, rx, ry);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ry, rx, vy, vx, ly, lx};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int spread(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic send_random();
    logic [COORD_W-1:0] lx, ly, vx, vy, rx, ry;
    int ax, ay, b, k;
    vx = COORD_W'($urandom);
    vy = COORD_W'($urandom);
    lx = COORD_W'($urandom);
    ly = COORD_W'($urandom);
    rx = COORD_W'($urandom);
    ry = COORD_W'($urandom);
    case ($urandom_range(0, 9))
      3, 4: begin
        lx = vx + COORD_W'(spread(1024));
        ly = vy + COORD_W'(spread(1024));
        rx = vx + COORD_W'(spread(1024));
        ry = vy + COORD_W'(spread(1024));
      end
      5: begin
        // collinear edges, same or opposite direction
        vx = COORD_W'(spread(1 << 20));
        vy = COORD_W'(spread(1 << 20));
        ax = spread(2048);
        ay = spread(2048);
        k = int'($urandom_range(0, 8)) - 4;
        lx = vx + COORD_W'(ax);
        ly = vy + COORD_W'(ay);
        rx = vx + COORD_W'(k * ax);
        ry = vy + COORD_W'(k * ay);
      end
      6: begin
        ax = spread(1 << 22);
        b = spread(1 << 22);
        lx = vx + COORD_W'(ax);
        ly = vy;
        if ($urandom_range(0, 1)) begin
          rx = vx;
          ry = vy + COORD_W'(b);
        end else begin
          rx = vx + COORD_W'(b);
          ry = vy;
        end
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          lx = vx;
          ly = vy;
        end else begin
          rx = vx;
          ry = vy;
        end
      end
      8, 9: begin
        lx = vx + COORD_W'(spread(1 << 20));
        ly = vy + COORD_W'(spread(1 << 20));
        rx = vx + COORD_W'(spread(1 << 20));
        ry = vy + COORD_W'(spread(1 << 20));
      end
      default: begin
      end
    endcase
    send_pts(lx, ly, vx, vy, rx, ry);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_limit('0);
    send_pts(0, 0, 0, 0, 0, 0);
    send_pts(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
    send_pts(C_MAX, 0, 0, 0, C_MIN, 0);
    send_pts(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN);
    send_pts(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN);
    send_pts(1, 0, 0, 0, 0, 1);
    send_pts(1, 0, 0, 0, 0, -1);
    send_pts(1, 0, 0, 0, -1, 0);
    send_pts(1, 0, 0, 0, -1, 1);
    send_pts(1, 0, 0, 0, -1, -1);
    send_pts(1, 0, 0, 0, 1, -1);
    send_pts(1, 0, 0, 0, 1, 0);
    send_pts(C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN);
    send_pts(0, C_MAX, 0, C_MIN, C_MAX, C_MIN);
    send_pts(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'hFFFFFF, 24'h000001);
    send_pts(C_MAX, 0, 0, 0, C_MAX, 1);
    send_pts(C_MAX, 0, 0, 0, C_MIN, 1);
    send_pts(C_MAX, 0, 0, 0, C_MIN, -1);

    // products right at the widest limit and one past it
    write_limit(LIMIT_MAX);
    send_pts(1, 0, 0, 0, 24'h0FFFFF, 0);
    send_pts(1, 0, 0, 0, 24'h100000, 0);
    send_pts(1, 0, 0, 0, 0, 24'h0FFFFF);
    send_pts(1, 0, 0, 0, 0, 24'h100000);
    repeat (200) send_random();

    // output held off while input keeps coming, pipeline fills up
    write_limit(LIMIT_W'($urandom_range(1, 1048574)));
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (250) send_random();

    write_limit('0);
    repeat (250) send_random();

    write_limit(LIMIT_W'($urandom_range(1, 4096)));
    idle_on = 1'b1;
    repeat (250) send_random();

    s_axis_tvalid <= 1'b0;
    drain();
    $display("sent %0d point triples across five limit settings incl. zero and full scale,",
             words_sent);
    $display("with one long output stall; %0d results checked, %0d flagged near zero",
             checked, flagged);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
